// ===== rtl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
package hcbp_pkg;

	localparam int BYTE_W           = 8;
	localparam int SYM_IN_W         = 8;
	localparam int CODE_W           = 32;
	localparam int LEN_W            = 6;
	localparam int CNT_W            = 3;
	localparam int PAD_W            = 3;
	localparam int MAX_OUT          = 4;
	localparam int IDX_W            = 2;
	localparam int NB_W             = 3;
	localparam int WORD_W           = BYTE_W + CODE_W;
	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_NUM_SYMBOLS  = 256;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
		logic [NB_W-1:0]                nbytes;
		logic [BYTE_W-1:0]              pend_byte;
		logic [CNT_W-1:0]               pend_cnt;
	} pack_res_t;

endpackage

// ===== rtl/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// Huffman encoder back end: code table and MSB-first byte packer.
// Input channel (in_valid / in_stall) takes one item per cycle while
// in_stall is low: op selects load of a table entry, encode of a symbol,
// or flush of the partial byte. Output channel (out_valid / out_stall)
// gives one result per cycle while out_stall is low. A load gives one
// result (load_error set for an overlong code of an in-range symbol), an
// encode gives one result per completed byte (0 to 4), a flush gives one
// result with the partial byte and its pad_bits count. An accepted item
// passes the table read register, then the result register, before its
// first result is valid. Throughput: one item per cycle while out_stall is
// low and each item gives at most one result; an encode giving more than
// one byte holds the input until its bytes leave the single byte-wide port.
// Reset clears the table valid bits (all entries read as empty), the
// pending byte and both pipeline stages. No clearing pass is needed.
// While out_stall is high the current result holds and in_stall rises
// once the item behind it has results to deliver.
module huffman_code_bit_packer import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [SYM_IN_W-1:0] symbol,
	input  logic [CODE_W-1:0]   code_bits,
	input  logic [LEN_W-1:0]    code_len,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                has_byte,
	output logic [PAD_W-1:0]    pad_bits,
	output logic                is_flush,
	output logic                load_error,
	output logic                last
);

	localparam int SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	logic                in_acc;
	logic                out_acc;
	logic [SYM_W-1:0]    sym_idx;
	logic                sym_ok;
	logic                len_bad;
	logic                tbl_we;
	entry_t              wr_ent;
	entry_t              rd_ent;
	logic [NUM_SYMBOLS-1:0] ent_vld_q;

	logic                valid_s1;
	logic [1:0]          op_s1;
	logic                sym_ok_s1;
	logic                err_s1;
	logic                ent_vld_s1;

	logic [BYTE_W-1:0]   pend_byte_q;
	logic [CNT_W-1:0]    pend_cnt_q;

	logic [LEN_W-1:0]    eff_len;
	pack_res_t           pk;
	logic [NB_W-1:0]     nres;
	logic                s2_free;
	logic                s1_adv;

	logic                valid_s2;
	logic [MAX_OUT-1:0][BYTE_W-1:0] bytes_s2;
	logic [IDX_W-1:0]    last_idx_s2;
	logic                has_s2;
	logic [PAD_W-1:0]    pad_s2;
	logic                flush_s2;
	logic                err_s2;
	logic [IDX_W-1:0]    idx_q;
	logic                at_last;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign sym_idx = symbol[SYM_W-1:0];
	assign sym_ok  = 32'(symbol) < NUM_SYMBOLS;
	assign len_bad = 32'(code_len) > LEN_LIMIT;
	assign tbl_we  = in_acc && (op == OP_LOAD) && sym_ok && !len_bad;
	assign wr_ent  = '{code: code_bits, len: code_len};

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SYMBOLS),
		.AW   (SYM_W)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(sym_idx),
		.wdata(wr_ent),
		.re   (in_acc),
		.raddr(sym_idx),
		.rdata(rd_ent)
	);

	// table entry valid bits, an entry never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (tbl_we) begin
			ent_vld_q[sym_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= op;
			sym_ok_s1  <= sym_ok;
			err_s1     <= sym_ok && len_bad;
			ent_vld_s1 <= ent_vld_q[sym_idx];
		end
	end

	assign eff_len = ent_vld_s1 ? rd_ent.len : '0;

	hcbp_pack u_pack (
		.pend_byte(pend_byte_q),
		.pend_cnt (pend_cnt_q),
		.code     (rd_ent.code),
		.len      (eff_len),
		.res      (pk)
	);

	always_comb begin
		case (op_s1)
			OP_LOAD:   nres = NB_W'(1);
			OP_FLUSH:  nres = NB_W'(1);
			OP_ENCODE: nres = sym_ok_s1 ? pk.nbytes : '0;
			default:   nres = '0;
		endcase
	end

	assign at_last = (idx_q == last_idx_s2);
	assign s2_free = !valid_s2 || (out_acc && at_last);
	assign s1_adv  = valid_s1 && ((nres == '0) || s2_free);
	assign in_stall = valid_s1 && !s1_adv;

	// pending partial byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_byte_q <= '0;
			pend_cnt_q  <= '0;
		end else if (s1_adv) begin
			if (op_s1 == OP_ENCODE && sym_ok_s1) begin
				pend_byte_q <= pk.pend_byte;
				pend_cnt_q  <= pk.pend_cnt;
			end else if (op_s1 == OP_FLUSH) begin
				pend_byte_q <= '0;
				pend_cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (s1_adv && (nres != '0)) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (out_acc && at_last) begin
			valid_s2 <= 1'b0;
		end else if (out_acc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (nres != '0)) begin
			last_idx_s2 <= IDX_W'(nres - NB_W'(1));
			case (op_s1)
				OP_LOAD: begin
					err_s2   <= err_s1;
					flush_s2 <= 1'b0;
					pad_s2   <= '0;
					has_s2   <= 1'b0;
					bytes_s2 <= '0;
				end
				OP_FLUSH: begin
					err_s2   <= 1'b0;
					flush_s2 <= 1'b1;
					has_s2   <= (pend_cnt_q != '0);
					pad_s2   <= (pend_cnt_q != '0) ?
						PAD_W'(BYTE_W) - PAD_W'(pend_cnt_q) : '0;
					bytes_s2 <= (pend_cnt_q != '0) ?
						(MAX_OUT*BYTE_W)'(pend_byte_q) : '0;
				end
				default: begin
					err_s2   <= 1'b0;
					flush_s2 <= 1'b0;
					pad_s2   <= '0;
					has_s2   <= 1'b1;
					bytes_s2 <= pk.bytes;
				end
			endcase
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte   = bytes_s2[idx_q];
	assign has_byte   = has_s2;
	assign pad_bits   = pad_s2;
	assign is_flush   = flush_s2;
	assign load_error = err_s2;
	assign last       = at_last;

endmodule

// ===== rtl/hcbp_ram.sv =====
`timescale 1ns / 1ps
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/hcbp_pack.sv =====
`timescale 1ns / 1ps
module hcbp_pack import hcbp_pkg::*; (
	input  logic [BYTE_W-1:0] pend_byte,
	input  logic [CNT_W-1:0]  pend_cnt,
	input  logic [CODE_W-1:0] code,
	input  logic [LEN_W-1:0]  len,
	output pack_res_t         res
);

	logic [LEN_W-1:0]  total;
	logic [LEN_W-1:0]  shamt;
	logic [CODE_W-1:0] code_al;
	logic [WORD_W-1:0] word;
	logic [NB_W-1:0]   nb;

	always_comb begin
		total   = LEN_W'(pend_cnt) + len;
		shamt   = LEN_W'(CODE_W) - len;
		// left-align the code, then place it right after the pending bits
		code_al = code << shamt;
		word    = {pend_byte, {CODE_W{1'b0}}} | ({code_al, {BYTE_W{1'b0}}} >> pend_cnt);
		nb      = total[LEN_W-1:CNT_W];

		for (int k = 0; k < MAX_OUT; k++) begin
			res.bytes[k] = word[WORD_W-1-BYTE_W*k -: BYTE_W];
		end
		res.nbytes   = nb;
		res.pend_cnt = total[CNT_W-1:0];
		case (nb)
			3'd0:    res.pend_byte = word[WORD_W-1 -: BYTE_W];
			3'd1:    res.pend_byte = word[WORD_W-1-BYTE_W -: BYTE_W];
			3'd2:    res.pend_byte = word[WORD_W-1-2*BYTE_W -: BYTE_W];
			3'd3:    res.pend_byte = word[WORD_W-1-3*BYTE_W -: BYTE_W];
			default: res.pend_byte = word[BYTE_W-1:0];
		endcase
	end

endmodule
